// ===== rtl/core/epoch_seconds_to_civil_date_top_macros.svh =====
// Assertion macros used by the epoch-to-date pipeline control
`ifndef EPOCH_SECONDS_TO_CIVIL_DATE_TOP_MACROS_SVH
`define EPOCH_SECONDS_TO_CIVIL_DATE_TOP_MACROS_SVH

// Check a condition in the same cycle as its trigger
`define EPC_ASSERT_NOW(name, clock, resetn, ante, cons) \
    name: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error("epoch-to-date pipeline check failed");

// Check a condition in the cycle after its trigger
`define EPC_ASSERT_NEXT(name, clock, resetn, ante, cons) \
    name: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error("epoch-to-date pipeline check failed");

`endif

// ===== rtl/core/epc_pkg.sv =====
// Shared constants, types and tables for the epoch-to-date pipeline
package epc_pkg;

    // Pipeline depth: register stages from input to result
    localparam int STAGES = 11;

    // Per-stage advance and valid bits handed from the controller to the datapath
    typedef struct packed {
        logic [STAGES-1:0] adv;
        logic [STAGES-1:0] valid;
    } pipe_ctl_t;

    // Offset that moves 0001-01-01 00:00:00 to zero, and the last legal offset
    localparam logic [39:0] SEC_OFFSET   = 40'd62135596800;
    localparam logic [38:0] SEC_SPAN_MAX = 39'd315537897599;

    // Seconds to days: shift by 7, then divide by 675 (86400 = 128 * 675)
    localparam logic [9:0]  DAY_DIV   = 10'd675;
    localparam int          DAY_SHIFT = 42;
    localparam logic [32:0] DAY_MUL   =
        33'(((64'd1 << DAY_SHIFT) + 64'(DAY_DIV) - 64'd1) / 64'(DAY_DIV));

    // Days from the March-based day count origin to 0001-01-01
    localparam logic [21:0] SHIFT_DAYS = 22'd306;

    // 400-year era
    localparam logic [21:0] ERA_DAYS  = 22'd146097;
    localparam int          ERA_SHIFT = 40;
    localparam logic [22:0] ERA_MUL   =
        23'(((64'd1 << ERA_SHIFT) + 64'(ERA_DAYS) - 64'd1) / 64'(ERA_DAYS));
    localparam logic [13:0] ERA_YEARS = 14'd400;

    // Hours within the day
    localparam logic [16:0] HOUR_SECS  = 17'd3600;
    localparam int          HOUR_SHIFT = 29;
    localparam logic [17:0] HOUR_MUL   =
        18'(((64'd1 << HOUR_SHIFT) + 64'(HOUR_SECS) - 64'd1) / 64'(HOUR_SECS));

    // Minutes within the hour
    localparam logic [11:0] MIN_SECS  = 12'd60;
    localparam int          MIN_SHIFT = 18;
    localparam logic [12:0] MIN_MUL   =
        13'(((64'd1 << MIN_SHIFT) + 64'(MIN_SECS) - 64'd1) / 64'(MIN_SECS));

    // Four-year cycles within an era
    localparam logic [17:0] QUAD_DAYS  = 18'd1460;
    localparam int          QUAD_SHIFT = 29;
    localparam logic [18:0] QUAD_MUL   =
        19'(((64'd1 << QUAD_SHIFT) + 64'(QUAD_DAYS) - 64'd1) / 64'(QUAD_DAYS));

    // Century boundaries within an era
    localparam logic [17:0] CENT1_DAYS = 18'd36524;
    localparam logic [17:0] CENT2_DAYS = 18'd73048;
    localparam logic [17:0] CENT3_DAYS = 18'd109572;
    localparam logic [17:0] ERA_LAST   = 18'd146096;

    // Year of era
    localparam logic [17:0] YEAR_DAYS  = 18'd365;
    localparam int          YEAR_SHIFT = 27;
    localparam logic [18:0] YEAR_MUL   =
        19'(((64'd1 << YEAR_SHIFT) + 64'(YEAR_DAYS) - 64'd1) / 64'(YEAR_DAYS));

    // March-based month index from day of year
    localparam logic [10:0] MP_DIV   = 11'd153;
    localparam int          MP_SHIFT = 19;
    localparam logic [11:0] MP_MUL   =
        12'(((64'd1 << MP_SHIFT) + 64'(MP_DIV) - 64'd1) / 64'(MP_DIV));

    // March-based month index of January
    localparam logic [3:0] MP_JANUARY = 4'd10;

    // First day of each March-based month, counted from March 1
    function automatic logic [8:0] month_offset(input logic [3:0] mp);
        logic [8:0] offs;
        unique case (mp)
            4'd0:    offs = 9'd0;
            4'd1:    offs = 9'd31;
            4'd2:    offs = 9'd61;
            4'd3:    offs = 9'd92;
            4'd4:    offs = 9'd122;
            4'd5:    offs = 9'd153;
            4'd6:    offs = 9'd184;
            4'd7:    offs = 9'd214;
            4'd8:    offs = 9'd245;
            4'd9:    offs = 9'd275;
            4'd10:   offs = 9'd306;
            4'd11:   offs = 9'd337;
            default: offs = 9'd0;
        endcase
        return offs;
    endfunction

endpackage

// ===== rtl/core/epc_pipe_ctl.sv =====
// Valid and advance control for the epoch-to-date pipeline stages
`include "epoch_seconds_to_civil_date_top_macros.svh"

module epc_pipe_ctl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               entry_valid,
    input  logic               exit_stall,
    output epc_pkg::pipe_ctl_t ctl
);

    localparam int Last = epc_pkg::STAGES - 1;

    logic [epc_pkg::STAGES-1:0] valid_reg;
    logic [epc_pkg::STAGES-1:0] valid_next;
    logic [epc_pkg::STAGES-1:0] full_above;
    logic [epc_pkg::STAGES-1:0] adv;

    // Mark stages whose own slot and every later slot are occupied
    for (genvar g = 0; g < epc_pkg::STAGES; g++)
    begin : g_full
        assign full_above[g] = &valid_reg[Last:g];
    end

    // Advance a stage unless it and everything downstream is full and stalled
    assign adv = ~full_above | {epc_pkg::STAGES{~exit_stall}};

    // Shift valid bits forward on advancing stages, hold the rest
    assign valid_next = (adv & {valid_reg[Last-1:0], entry_valid}) | (~adv & valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign ctl = '{adv: adv, valid: valid_reg};

    // Stall the input only when every stage holds an item
    `EPC_ASSERT_NOW(a_stall_only_when_full, clk, rst_n, !adv[0], &valid_reg)
    // Track items: count changes by accepted minus delivered
    `EPC_ASSERT_NEXT(a_item_count, clk, rst_n, rst_n, $countones(valid_reg) == $past($countones(valid_reg)) + $past(entry_valid && adv[0]) - $past(valid_reg[Last] && !exit_stall))
    // Never drop an item from the first stage
    `EPC_ASSERT_NEXT(a_first_stage_kept, clk, rst_n, valid_reg[0], valid_reg[0] || valid_reg[1])

endmodule

// ===== rtl/core/epoch_seconds_to_civil_date_top.sv =====
// Top level: Unix seconds to Gregorian date and time of day, eleven-stage pipeline
//
// channel  | handshake                     | payload
// ---------+-------------------------------+------------------------------------------
// seconds  | seconds_valid, seconds_stall  | unix_seconds
// date     | date_valid, date_stall        | year, month, day, hour, minute, second,
//          |                               | day_in_year, out_of_range
//
// One item per cycle unless seconds_stall is high; each result is offered from the
// last stage register. The depth comes from the chain of constant-reciprocal
// multiplies (days, era, year of era, month), each followed by a register.
// Reset clears the stage valid bits only; payload registers start unknown.
// A stalled result holds its stage; earlier stages keep filling bubbles, so
// seconds_stall rises only when all eleven stages hold an item.

module epoch_seconds_to_civil_date_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               seconds_valid,
    output logic               seconds_stall,
    input  logic signed [38:0] unix_seconds,
    output logic               date_valid,
    input  logic               date_stall,
    output logic [13:0]        year,
    output logic [3:0]         month,
    output logic [4:0]         day,
    output logic [4:0]         hour,
    output logic [5:0]         minute,
    output logic [5:0]         second,
    output logic [8:0]         day_in_year,
    output logic               out_of_range
);

    localparam logic [8:0] YoeCent1  = 9'd100;
    localparam logic [8:0] YoeCent2  = 9'd200;
    localparam logic [8:0] YoeCent3  = 9'd300;
    localparam logic [8:0] MarToJan  = 9'd305;
    localparam logic [8:0] JanFebLen = 9'd60;

    epc_pkg::pipe_ctl_t ctl;

    epc_pipe_ctl u_ctl (
        .clk         (clk),
        .rst_n       (rst_n),
        .entry_valid (seconds_valid),
        .exit_stall  (date_stall),
        .ctl         (ctl)
    );

    assign seconds_stall = !ctl.adv[0];
    assign date_valid    = ctl.valid[epc_pkg::STAGES-1];

    // ---------------- Stage 1: range check, move origin to year 1
    logic [39:0] s1_off_next;
    logic        s1_oor_next;
    logic [38:0] s1_secs_reg;
    logic        s1_oor_reg;

    assign s1_off_next = {unix_seconds[38], unix_seconds} + epc_pkg::SEC_OFFSET;
    assign s1_oor_next = s1_off_next[39] || (s1_off_next[38:0] > epc_pkg::SEC_SPAN_MAX);

    always_ff @(posedge clk)
    begin
        if (ctl.adv[0])
        begin
            s1_secs_reg <= s1_oor_next ? '0 : s1_off_next[38:0];
            s1_oor_reg  <= s1_oor_next;
        end
    end

    // ---------------- Stage 2: day count by reciprocal multiply
    logic [64:0] s2_prod;
    logic [21:0] s2_days_reg;
    logic [9:0]  s2_q0lo_reg;
    logic [6:0]  s2_lo7_reg;
    logic        s2_oor_reg;

    assign s2_prod = {33'd0, s1_secs_reg[38:7]} * {32'd0, epc_pkg::DAY_MUL};

    always_ff @(posedge clk)
    begin
        if (ctl.adv[1])
        begin
            s2_days_reg <= s2_prod[63:42];
            s2_q0lo_reg <= s1_secs_reg[16:7];
            s2_lo7_reg  <= s1_secs_reg[6:0];
            s2_oor_reg  <= s1_oor_reg;
        end
    end

    // ---------------- Stage 3: second of day, March-based day number
    logic [19:0] s3_base;
    logic [9:0]  s3_rem;
    logic [21:0] s3_z_reg;
    logic [16:0] s3_sod_reg;
    logic        s3_oor_reg;

    // Remainder is below 675, so the low ten bits are enough
    assign s3_base = {10'd0, s2_days_reg[9:0]} * {10'd0, epc_pkg::DAY_DIV};
    assign s3_rem  = s2_q0lo_reg - s3_base[9:0];

    always_ff @(posedge clk)
    begin
        if (ctl.adv[2])
        begin
            s3_z_reg   <= s2_days_reg + epc_pkg::SHIFT_DAYS;
            s3_sod_reg <= {s3_rem, s2_lo7_reg};
            s3_oor_reg <= s2_oor_reg;
        end
    end

    // ---------------- Stage 4: era and hour by reciprocal multiply
    logic [44:0] s4_era_prod;
    logic [34:0] s4_hour_prod;
    logic [21:0] s4_z_reg;
    logic [4:0]  s4_era_reg;
    logic [16:0] s4_sod_reg;
    logic [4:0]  s4_hour_reg;
    logic        s4_oor_reg;

    assign s4_era_prod  = {23'd0, s3_z_reg} * {22'd0, epc_pkg::ERA_MUL};
    assign s4_hour_prod = {18'd0, s3_sod_reg} * {17'd0, epc_pkg::HOUR_MUL};

    always_ff @(posedge clk)
    begin
        if (ctl.adv[3])
        begin
            s4_z_reg    <= s3_z_reg;
            s4_era_reg  <= s4_era_prod[44:40];
            s4_sod_reg  <= s3_sod_reg;
            s4_hour_reg <= s4_hour_prod[33:29];
            s4_oor_reg  <= s3_oor_reg;
        end
    end

    // ---------------- Stage 5: day of era, second within hour
    logic [21:0] s5_era_base;
    logic [21:0] s5_doe_next;
    logic [16:0] s5_hour_base;
    logic [16:0] s5_remh_next;
    logic [17:0] s5_doe_reg;
    logic [4:0]  s5_era_reg;
    logic [4:0]  s5_hour_reg;
    logic [11:0] s5_remh_reg;
    logic        s5_oor_reg;

    assign s5_era_base  = {17'd0, s4_era_reg} * epc_pkg::ERA_DAYS;
    assign s5_doe_next  = s4_z_reg - s5_era_base;
    assign s5_hour_base = {12'd0, s4_hour_reg} * epc_pkg::HOUR_SECS;
    assign s5_remh_next = s4_sod_reg - s5_hour_base;

    always_ff @(posedge clk)
    begin
        if (ctl.adv[4])
        begin
            s5_doe_reg  <= s5_doe_next[17:0];
            s5_era_reg  <= s4_era_reg;
            s5_hour_reg <= s4_hour_reg;
            s5_remh_reg <= s5_remh_next[11:0];
            s5_oor_reg  <= s4_oor_reg;
        end
    end

    // ---------------- Stage 6: leap-day corrections within the era, minute
    logic [36:0] s6_quad_prod;
    logic [24:0] s6_min_prod;
    logic [2:0]  s6_cent_next;
    logic [17:0] s6_doe_reg;
    logic [4:0]  s6_era_reg;
    logic [6:0]  s6_quad_reg;
    logic [2:0]  s6_cent_reg;
    logic        s6_last_reg;
    logic [4:0]  s6_hour_reg;
    logic [11:0] s6_remh_reg;
    logic [5:0]  s6_minute_reg;
    logic        s6_oor_reg;

    assign s6_quad_prod = {19'd0, s5_doe_reg} * {18'd0, epc_pkg::QUAD_MUL};
    assign s6_min_prod  = {13'd0, s5_remh_reg} * {12'd0, epc_pkg::MIN_MUL};
    assign s6_cent_next = {2'd0, s5_doe_reg >= epc_pkg::CENT1_DAYS}
                        + {2'd0, s5_doe_reg >= epc_pkg::CENT2_DAYS}
                        + {2'd0, s5_doe_reg >= epc_pkg::CENT3_DAYS}
                        + {2'd0, s5_doe_reg >= epc_pkg::ERA_LAST};

    always_ff @(posedge clk)
    begin
        if (ctl.adv[5])
        begin
            s6_doe_reg    <= s5_doe_reg;
            s6_era_reg    <= s5_era_reg;
            s6_quad_reg   <= s6_quad_prod[35:29];
            s6_cent_reg   <= s6_cent_next;
            s6_last_reg   <= (s5_doe_reg == epc_pkg::ERA_LAST);
            s6_hour_reg   <= s5_hour_reg;
            s6_remh_reg   <= s5_remh_reg;
            s6_minute_reg <= s6_min_prod[23:18];
            s6_oor_reg    <= s5_oor_reg;
        end
    end

    // ---------------- Stage 7: leap-free day count, second
    logic [17:0] s7_numer_next;
    logic [11:0] s7_min_base;
    logic [11:0] s7_sec_next;
    logic [17:0] s7_numer_reg;
    logic [17:0] s7_doe_reg;
    logic [4:0]  s7_era_reg;
    logic [4:0]  s7_hour_reg;
    logic [5:0]  s7_minute_reg;
    logic [5:0]  s7_second_reg;
    logic        s7_oor_reg;

    assign s7_numer_next = s6_doe_reg - {11'd0, s6_quad_reg} + {15'd0, s6_cent_reg}
                         - {17'd0, s6_last_reg};
    assign s7_min_base   = {6'd0, s6_minute_reg} * epc_pkg::MIN_SECS;
    assign s7_sec_next   = s6_remh_reg - s7_min_base;

    always_ff @(posedge clk)
    begin
        if (ctl.adv[6])
        begin
            s7_numer_reg  <= s7_numer_next;
            s7_doe_reg    <= s6_doe_reg;
            s7_era_reg    <= s6_era_reg;
            s7_hour_reg   <= s6_hour_reg;
            s7_minute_reg <= s6_minute_reg;
            s7_second_reg <= s7_sec_next[5:0];
            s7_oor_reg    <= s6_oor_reg;
        end
    end

    // ---------------- Stage 8: year of era by reciprocal multiply
    logic [36:0] s8_yoe_prod;
    logic [8:0]  s8_yoe_reg;
    logic [17:0] s8_doe_reg;
    logic [4:0]  s8_era_reg;
    logic [4:0]  s8_hour_reg;
    logic [5:0]  s8_minute_reg;
    logic [5:0]  s8_second_reg;
    logic        s8_oor_reg;

    assign s8_yoe_prod = {19'd0, s7_numer_reg} * {18'd0, epc_pkg::YEAR_MUL};

    always_ff @(posedge clk)
    begin
        if (ctl.adv[7])
        begin
            s8_yoe_reg    <= s8_yoe_prod[35:27];
            s8_doe_reg    <= s7_doe_reg;
            s8_era_reg    <= s7_era_reg;
            s8_hour_reg   <= s7_hour_reg;
            s8_minute_reg <= s7_minute_reg;
            s8_second_reg <= s7_second_reg;
            s8_oor_reg    <= s7_oor_reg;
        end
    end

    // ---------------- Stage 9: day of March-based year, leap flag
    logic [1:0]  s9_cent;
    logic [17:0] s9_year_start;
    logic [17:0] s9_doy_next;
    logic        s9_leap_next;
    logic [8:0]  s9_doy_reg;
    logic [8:0]  s9_yoe_reg;
    logic        s9_leap_reg;
    logic [4:0]  s9_era_reg;
    logic [4:0]  s9_hour_reg;
    logic [5:0]  s9_minute_reg;
    logic [5:0]  s9_second_reg;
    logic        s9_oor_reg;

    assign s9_cent       = {1'b0, s8_yoe_reg >= YoeCent1} + {1'b0, s8_yoe_reg >= YoeCent2}
                         + {1'b0, s8_yoe_reg >= YoeCent3};
    assign s9_year_start = {9'd0, s8_yoe_reg} * epc_pkg::YEAR_DAYS
                         + {11'd0, s8_yoe_reg[8:2]} - {16'd0, s9_cent};
    assign s9_doy_next   = s8_doe_reg - s9_year_start;
    // Era-aligned year: leap when divisible by 4 and not a plain century
    assign s9_leap_next  = (s8_yoe_reg[1:0] == 2'd0) && (s8_yoe_reg != YoeCent1)
                         && (s8_yoe_reg != YoeCent2) && (s8_yoe_reg != YoeCent3);

    always_ff @(posedge clk)
    begin
        if (ctl.adv[8])
        begin
            s9_doy_reg    <= s9_doy_next[8:0];
            s9_yoe_reg    <= s8_yoe_reg;
            s9_leap_reg   <= s9_leap_next;
            s9_era_reg    <= s8_era_reg;
            s9_hour_reg   <= s8_hour_reg;
            s9_minute_reg <= s8_minute_reg;
            s9_second_reg <= s8_second_reg;
            s9_oor_reg    <= s8_oor_reg;
        end
    end

    // ---------------- Stage 10: March-based month by reciprocal multiply
    logic [10:0] s10_mp_arg;
    logic [22:0] s10_mp_prod;
    logic [3:0]  s10_mp_reg;
    logic [8:0]  s10_doy_reg;
    logic [8:0]  s10_yoe_reg;
    logic        s10_leap_reg;
    logic [4:0]  s10_era_reg;
    logic [4:0]  s10_hour_reg;
    logic [5:0]  s10_minute_reg;
    logic [5:0]  s10_second_reg;
    logic        s10_oor_reg;

    assign s10_mp_arg  = {s9_doy_reg, 2'b00} + {2'd0, s9_doy_reg} + 11'd2;
    assign s10_mp_prod = {12'd0, s10_mp_arg} * {11'd0, epc_pkg::MP_MUL};

    always_ff @(posedge clk)
    begin
        if (ctl.adv[9])
        begin
            s10_mp_reg     <= s10_mp_prod[22:19];
            s10_doy_reg    <= s9_doy_reg;
            s10_yoe_reg    <= s9_yoe_reg;
            s10_leap_reg   <= s9_leap_reg;
            s10_era_reg    <= s9_era_reg;
            s10_hour_reg   <= s9_hour_reg;
            s10_minute_reg <= s9_minute_reg;
            s10_second_reg <= s9_second_reg;
            s10_oor_reg    <= s9_oor_reg;
        end
    end

    // ---------------- Stage 11: civil fields, zeroed when out of range
    logic        s11_jan_feb;
    logic [8:0]  s11_dom;
    logic [3:0]  s11_month_next;
    logic [13:0] s11_year_next;
    logic [8:0]  s11_yday_next;
    logic [13:0] year_reg;
    logic [3:0]  month_reg;
    logic [4:0]  day_reg;
    logic [4:0]  hour_reg;
    logic [5:0]  minute_reg;
    logic [5:0]  second_reg;
    logic [8:0]  yday_reg;
    logic        oor_reg;

    assign s11_jan_feb    = (s10_mp_reg >= epc_pkg::MP_JANUARY);
    assign s11_dom        = s10_doy_reg - epc_pkg::month_offset(s10_mp_reg) + 9'd1;
    assign s11_month_next = s11_jan_feb ? s10_mp_reg - 4'd9 : s10_mp_reg + 4'd3;
    assign s11_year_next  = {9'd0, s10_era_reg} * epc_pkg::ERA_YEARS
                          + {5'd0, s10_yoe_reg} + {13'd0, s11_jan_feb};
    assign s11_yday_next  = s11_jan_feb ? s10_doy_reg - MarToJan
                                        : s10_doy_reg + JanFebLen + {8'd0, s10_leap_reg};

    always_ff @(posedge clk)
    begin
        if (ctl.adv[10])
        begin
            year_reg   <= s10_oor_reg ? '0 : s11_year_next;
            month_reg  <= s10_oor_reg ? '0 : s11_month_next;
            day_reg    <= s10_oor_reg ? '0 : s11_dom[4:0];
            hour_reg   <= s10_oor_reg ? '0 : s10_hour_reg;
            minute_reg <= s10_oor_reg ? '0 : s10_minute_reg;
            second_reg <= s10_oor_reg ? '0 : s10_second_reg;
            yday_reg   <= s10_oor_reg ? '0 : s11_yday_next;
            oor_reg    <= s10_oor_reg;
        end
    end

    assign year         = year_reg;
    assign month        = month_reg;
    assign day          = day_reg;
    assign hour         = hour_reg;
    assign minute       = minute_reg;
    assign second       = second_reg;
    assign day_in_year  = yday_reg;
    assign out_of_range = oor_reg;

endmodule
